// ===== hw/rtl/reader_writer_lock_arbiter_core_macros.svh =====
// Assertion macros shared by the lock arbiter RTL.
`ifndef READER_WRITER_LOCK_ARBITER_CORE_MACROS_SVH
`define READER_WRITER_LOCK_ARBITER_CORE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define RWLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define RWLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rwla_pkg.sv =====
`timescale 1ns / 1ps

package rwla_pkg;

    localparam int MAX_TASKS  = 64;
    localparam int DEPTH_BITS = 8;
    localparam int ID_W       = 6;
    localparam int ID_COUNT   = 1 << ID_W;
    localparam int SLOT_W     = $clog2(MAX_TASKS);
    localparam int COUNT_W    = 16;
    localparam int WAIT_W     = 7;

    localparam logic [COUNT_W-1:0]    COUNT_MAX  = '1;
    localparam logic [WAIT_W-1:0]     WAIT_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0] RDEPTH_MAX = '1;

    typedef enum logic [1:0] {
        OP_READ_ACQ  = 2'd0,
        OP_READ_REL  = 2'd1,
        OP_WRITE_ACQ = 2'd2,
        OP_WRITE_REL = 2'd3
    } op_t;

    typedef struct packed {
        op_t             operation;
        logic [ID_W-1:0] task_id;
        logic            task_present;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic               misuse_warning;
        logic               wake_waiters;
        logic [COUNT_W-1:0] reader_count;
        logic               write_held;
        logic               is_locked;
    } rsp_t;

    typedef struct packed {
        logic                  queued;
        logic [DEPTH_BITS-1:0] read_depth;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef logic [SLOT_W-1:0] slot_lut_t [ID_COUNT];

    function automatic slot_lut_t build_slot_lut();
        slot_lut_t lut;
        for (int i = 0; i < ID_COUNT; i++)
        begin
            lut[i] = SLOT_W'(i % MAX_TASKS);
        end
        return lut;
    endfunction

    // Maps a task identifier to its table entry.
    localparam slot_lut_t SLOT_LUT = build_slot_lut();

endpackage

// ===== hw/rtl/rwla_req_if.sv =====
`timescale 1ns / 1ps

interface rwla_req_if;
    logic          valid;
    logic          ready;
    rwla_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rwla_rsp_if.sv =====
`timescale 1ns / 1ps

interface rwla_rsp_if;
    logic          valid;
    logic          ready;
    rwla_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/reader_writer_lock_arbiter_core.sv =====
`timescale 1ns / 1ps
// Reader-writer lock arbiter for one semaphore, with writer preference.
// The req channel carries one word per request: an operation (read attempt,
// read release, write attempt, write release), a task identifier and a flag
// that says whether a task is present. The rsp channel returns one word per
// request: granted, misuse warning, wake request and the lock state after it.
// Both channels complete a transfer when valid and ready are high at a clock edge.
// A request is accepted into the execute-stage registers while its per-task
// entry is read from a synchronous table; its response is then loaded into
// the output register, which offers it on rsp until it is taken.
// Sustained throughput is one request per cycle while rsp.ready stays high; a
// write-back to the entry that the next request reads is forwarded around the table.
// After reset the per-task table is swept to zero, one entry per cycle, over
// all MAX_TASKS entries; req.ready stays low during the sweep.
// When the receiver stalls, the response waits in the output register; the
// request behind it is held in the execute stage and req.ready drops until
// the output register frees up.
module reader_writer_lock_arbiter_core (
    input  logic            clk,
    input  logic            rst_n,
    rwla_req_if.sink        req,
    rwla_rsp_if.source      rsp
);

    `include "reader_writer_lock_arbiter_core_macros.svh"

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [rwla_pkg::SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [rwla_pkg::COUNT_W-1:0] shared_reg, shared_next;
    logic                         xflag_reg, xflag_next;
    logic [rwla_pkg::ID_W-1:0]    xowner_reg, xowner_next;
    logic [rwla_pkg::COUNT_W-1:0] xdepth_reg, xdepth_next;
    logic [rwla_pkg::WAIT_W-1:0]  waiting_reg, waiting_next;

    rwla_pkg::op_t               op_reg;
    logic [rwla_pkg::ID_W-1:0]   id_reg;
    logic                        present_reg;
    logic [rwla_pkg::SLOT_W-1:0] slot_reg;

    logic            fwd_hit_reg;
    rwla_pkg::entry_t fwd_data_reg;

    logic            out_valid_reg;
    rwla_pkg::rsp_t  out_data_reg;

    logic                        clearing;
    logic                        can_commit;
    logic                        accept;
    logic [rwla_pkg::ID_W-1:0]   id_in;
    logic [rwla_pkg::SLOT_W-1:0] slot_in;

    logic                         ram_we;
    logic [rwla_pkg::SLOT_W-1:0]  ram_waddr;
    logic [rwla_pkg::ENTRY_W-1:0] ram_wdata;
    logic [rwla_pkg::ENTRY_W-1:0] ram_rdata;

    rwla_pkg::entry_t entry_cur;
    rwla_pkg::entry_t entry_new;
    rwla_pkg::rsp_t   rsp_new;

    assign clearing   = (state_reg == S_CLEAR);
    assign can_commit = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign req.ready  = (state_reg == S_IDLE) || can_commit;
    assign accept     = req.valid && req.ready;
    assign id_in      = req.data.task_present ? req.data.task_id : '0;
    assign slot_in    = rwla_pkg::SLOT_LUT[id_in];

    assign ram_we    = clearing || can_commit;
    assign ram_waddr = clearing ? clr_cnt_reg : slot_reg;
    assign ram_wdata = clearing ? '0 : entry_new;

    rwla_ram #(
        .WIDTH (rwla_pkg::ENTRY_W),
        .DEPTH (rwla_pkg::MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (slot_in),
        .rdata (ram_rdata)
    );

    assign entry_cur = fwd_hit_reg ? fwd_data_reg : rwla_pkg::entry_t'(ram_rdata);

    always_comb
    begin
        logic granted;
        logic warn;
        logic wake;
        logic owned;
        logic defer;
        logic take;

        granted      = 1'b1;
        warn         = 1'b0;
        wake         = 1'b0;
        take         = 1'b0;
        defer        = 1'b0;
        owned        = xflag_reg && (xowner_reg == id_reg);
        entry_new    = entry_cur;
        shared_next  = shared_reg;
        xflag_next   = xflag_reg;
        xowner_next  = xowner_reg;
        xdepth_next  = xdepth_reg;
        waiting_next = waiting_reg;

        unique case (op_reg)
            rwla_pkg::OP_READ_ACQ:
            begin
                if (owned && present_reg)
                begin
                    if (xdepth_reg == rwla_pkg::COUNT_MAX)
                    begin
                        granted = 1'b0;
                        warn    = 1'b1;
                    end
                    else
                    begin
                        xdepth_next = xdepth_reg + 1'b1;
                    end
                end
                else
                begin
                    defer = (waiting_reg != '0)
                            && !(present_reg && (entry_cur.read_depth != '0));
                    if (xflag_reg || defer)
                    begin
                        granted = 1'b0;
                    end
                    else if ((shared_reg == rwla_pkg::COUNT_MAX) || (present_reg
                             && (entry_cur.read_depth == rwla_pkg::RDEPTH_MAX)))
                    begin
                        granted = 1'b0;
                        warn    = 1'b1;
                    end
                    else
                    begin
                        shared_next = shared_reg + 1'b1;
                        if (present_reg)
                        begin
                            entry_new.read_depth = entry_cur.read_depth + 1'b1;
                        end
                    end
                end
            end
            rwla_pkg::OP_READ_REL:
            begin
                if (owned && present_reg)
                begin
                    warn = (xdepth_reg <= rwla_pkg::COUNT_W'(1));
                    if (xdepth_reg != '0)
                    begin
                        xdepth_next = xdepth_reg - 1'b1;
                    end
                end
                else
                begin
                    if (shared_reg == '0)
                    begin
                        warn = 1'b1;
                    end
                    else
                    begin
                        shared_next = shared_reg - 1'b1;
                    end
                    if (present_reg && (entry_cur.read_depth != '0))
                    begin
                        entry_new.read_depth = entry_cur.read_depth - 1'b1;
                    end
                    wake = (shared_next == '0);
                end
            end
            rwla_pkg::OP_WRITE_ACQ:
            begin
                if (owned)
                begin
                    if (xdepth_reg == rwla_pkg::COUNT_MAX)
                    begin
                        granted = 1'b0;
                        warn    = 1'b1;
                    end
                    else
                    begin
                        xdepth_next = xdepth_reg + 1'b1;
                        take        = 1'b1;
                    end
                end
                else if (!xflag_reg && (shared_reg == '0))
                begin
                    xflag_next  = 1'b1;
                    xowner_next = id_reg;
                    xdepth_next = rwla_pkg::COUNT_W'(1);
                    take        = 1'b1;
                end
                else
                begin
                    granted = 1'b0;
                    if (!entry_cur.queued)
                    begin
                        entry_new.queued = 1'b1;
                        if (waiting_reg == rwla_pkg::WAIT_MAX)
                        begin
                            warn = 1'b1;
                        end
                        else
                        begin
                            waiting_next = waiting_reg + 1'b1;
                        end
                    end
                end
                if (take && entry_cur.queued)
                begin
                    entry_new.queued = 1'b0;
                    if (waiting_reg != '0)
                    begin
                        waiting_next = waiting_reg - 1'b1;
                    end
                end
            end
            rwla_pkg::OP_WRITE_REL:
            begin
                warn = !xflag_reg || (xdepth_reg == '0);
                if (xdepth_reg > rwla_pkg::COUNT_W'(1))
                begin
                    xdepth_next = xdepth_reg - 1'b1;
                end
                else
                begin
                    xflag_next  = 1'b0;
                    xowner_next = '0;
                    xdepth_next = '0;
                    wake        = 1'b1;
                end
            end
            default:
            begin
                granted = 1'b1;
            end
        endcase

        rsp_new.granted        = granted;
        rsp_new.misuse_warning = warn;
        rsp_new.wake_waiters   = wake;
        rsp_new.reader_count   = shared_next;
        rsp_new.write_held     = xflag_next;
        rsp_new.is_locked      = xflag_next || (shared_next != '0);
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == rwla_pkg::SLOT_W'(rwla_pkg::MAX_TASKS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_commit && !accept)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            shared_reg    <= '0;
            xflag_reg     <= 1'b0;
            xowner_reg    <= '0;
            xdepth_reg    <= '0;
            waiting_reg   <= '0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (can_commit)
            begin
                shared_reg  <= shared_next;
                xflag_reg   <= xflag_next;
                xowner_reg  <= xowner_next;
                xdepth_reg  <= xdepth_next;
                waiting_reg <= waiting_next;
            end
            if (can_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                fwd_hit_reg <= can_commit && (slot_in == slot_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.data.operation;
            id_reg       <= id_in;
            present_reg  <= req.data.task_present;
            slot_reg     <= slot_in;
            fwd_data_reg <= entry_new;
        end
        if (can_commit)
        begin
            out_data_reg <= rsp_new;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    `RWLA_ASSERT_SAME(a_depth_clear_when_free, !xflag_reg, xdepth_reg == '0,
        "Write depth is nonzero while the lock is not held exclusively.")
    `RWLA_ASSERT_NEXT(a_denied_keeps_readers, can_commit && !rsp_new.granted,
        $stable(shared_reg), "A denied request changed the reader count.")
    `RWLA_ASSERT_SAME(a_no_accept_in_sweep, clearing, !req.ready,
        "A request word was accepted during the table sweep.")

endmodule

// ===== hw/rtl/rwla_ram.sv =====
`timescale 1ns / 1ps

module rwla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
